@@ design/snaw_pkg.sv @@
// Shared definitions for the strided N-D address walker.
// Register indexes, default sizes and the cell control bundle. No dependencies.
package snaw_pkg;

  localparam int DEF_MAX_DIMS  = 4;
  localparam int DEF_DIM_BITS  = 16;
  localparam int DEF_ADDR_BITS = 32;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;
  localparam int PACK_BITS     = 64;   // packed size/stride registers
  localparam int WORD_BITS     = 32;   // bases, addresses out, index
  localparam int NDIM_BITS     = 3;    // num_dims register
  localparam int NDIM_EFF_BITS = 4;    // saturated dim count, holds up to 15

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_NUM_DIMS  = 3'd0,
    CFG_DIM_SIZES = 3'd1,
    CFG_A_STRIDES = 3'd2,
    CFG_B_STRIDES = 3'd3,
    CFG_A_BASE    = 3'd4,
    CFG_B_BASE    = 3'd5
  } cfg_reg_t;

  // Per-tick control broadcast to every dimension cell.
  typedef struct packed {
    logic start;    // tick reloads counters from zero
    logic advance;  // tick produces a result and steps the odometer
  } snaw_ctl_t;

endpackage

@@ design/snaw_cell.sv @@
// One dimension cell: counter digit, carry link and precomputed address step.
// Depends on snaw_pkg for the control bundle.
module snaw_cell #(
  parameter int DIM_BITS  = snaw_pkg::DEF_DIM_BITS,
  parameter int ADDR_BITS = snaw_pkg::DEF_ADDR_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  snaw_pkg::snaw_ctl_t   ctl,
  input  logic                  in_use,
  input  logic [DIM_BITS-1:0]   size,
  input  logic [DIM_BITS-1:0]   a_stride,
  input  logic [DIM_BITS-1:0]   b_stride,
  input  logic                  carry_in,
  output logic                  carry_out,
  output logic                  inc,
  input  logic [ADDR_BITS-1:0]  sfx_a_in,
  input  logic [ADDR_BITS-1:0]  sfx_b_in,
  output logic [ADDR_BITS-1:0]  sfx_a_out,
  output logic [ADDR_BITS-1:0]  sfx_b_out,
  output logic [ADDR_BITS-1:0]  delta_a,
  output logic [ADDR_BITS-1:0]  delta_b
);
  import snaw_pkg::*;

  logic [DIM_BITS-1:0]   cnt;
  logic [DIM_BITS-1:0]   cnt_next;
  logic [DIM_BITS-1:0]   cnt_cur;
  logic                  wrap;
  logic [DIM_BITS-1:0]   size_m1;
  logic [2*DIM_BITS-1:0] prod_a;
  logic [2*DIM_BITS-1:0] prod_b;
  logic [ADDR_BITS-1:0]  rew_a;
  logic [ADDR_BITS-1:0]  rew_b;

  assign cnt_cur   = ctl.start ? '0 : cnt;
  assign wrap      = ({1'b0, cnt_cur} + (DIM_BITS+1)'(1)) >= {1'b0, size};
  assign carry_out = in_use ? (carry_in & wrap) : carry_in;
  assign inc       = in_use & carry_in & ~wrap;

  always_comb begin
    cnt_next = cnt_cur;
    if (in_use && carry_in) begin
      cnt_next = wrap ? '0 : cnt_cur + DIM_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.advance) begin
      cnt <= cnt_next;
    end
  end

  // Rewind of this digit: (size-1)*stride. Suffix sums of inner rewinds
  // ripple outward one cell per cycle; the step taken when this digit
  // increments is its stride minus the rewinds of all inner digits.
  assign size_m1 = size - DIM_BITS'(1);
  assign prod_a  = {{DIM_BITS{1'b0}}, size_m1} * {{DIM_BITS{1'b0}}, a_stride};
  assign prod_b  = {{DIM_BITS{1'b0}}, size_m1} * {{DIM_BITS{1'b0}}, b_stride};

  always_ff @(posedge clk) begin
    rew_a     <= in_use ? ADDR_BITS'(prod_a) : '0;
    rew_b     <= in_use ? ADDR_BITS'(prod_b) : '0;
    sfx_a_out <= sfx_a_in + rew_a;
    sfx_b_out <= sfx_b_in + rew_b;
    delta_a   <= ADDR_BITS'(a_stride) - sfx_a_in;
    delta_b   <= ADDR_BITS'(b_stride) - sfx_b_in;
  end

endmodule

@@ design/strided_nd_address_walker_unit.sv @@
// Top level of the strided N-D address walker: config registers, walk state,
// output register and the row of dimension cells. Depends on snaw_pkg, snaw_cell.
//
//  channel | signals                                   | accepted when
//  --------+-------------------------------------------+----------------------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | cfg_valid & cfg_ready
//  in      | in_valid in_ready restart                 | in_valid & in_ready
//  out     | out_valid out_ready a_addr b_addr         | out_valid & out_ready
//          | out_index last                            |
//
// One element request per cycle while in_ready is high; its result is
// registered and shows the next cycle. The carry ripples through the
// MAX_DIMS cells combinationally. After reset and after every config write,
// in_ready stays low while the per-cell address steps settle through the chain.
// in_ready also drops only when the output register is full and not taken.
// A request that hits a zero-sized dimension is consumed with no result.
module strided_nd_address_walker_unit #(
  parameter int MAX_DIMS  = snaw_pkg::DEF_MAX_DIMS,
  parameter int DIM_BITS  = snaw_pkg::DEF_DIM_BITS,
  parameter int ADDR_BITS = snaw_pkg::DEF_ADDR_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [snaw_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [snaw_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [snaw_pkg::WORD_BITS-1:0]      a_addr,
  output logic [snaw_pkg::WORD_BITS-1:0]      b_addr,
  output logic [snaw_pkg::WORD_BITS-1:0]      out_index,
  output logic                                last
);
  import snaw_pkg::*;

  localparam int SETTLE     = MAX_DIMS + 2;
  localparam int SETTLE_W   = $clog2(SETTLE + 1);
  localparam int WIDE_BITS  = 2 * PACK_BITS;

  // configuration registers
  logic [NDIM_BITS-1:0] num_dims;
  logic [PACK_BITS-1:0] dim_sizes;
  logic [PACK_BITS-1:0] a_strides;
  logic [PACK_BITS-1:0] b_strides;
  logic [WORD_BITS-1:0] a_base;
  logic [WORD_BITS-1:0] b_base;

  // walk state
  logic [ADDR_BITS-1:0] a_pos;
  logic [ADDR_BITS-1:0] b_pos;
  logic [WORD_BITS-1:0] count;
  logic                 walk_active;
  logic [SETTLE_W-1:0]  settle;

  logic                 cfg_take;
  logic                 take;
  logic                 emit;
  logic                 start;
  logic                 zero_size;
  logic                 last_w;
  logic [NDIM_EFF_BITS-1:0] nd_eff;
  logic [WIDE_BITS-1:0] sizes_wide;
  logic [WIDE_BITS-1:0] astr_wide;
  logic [WIDE_BITS-1:0] bstr_wide;
  logic [ADDR_BITS-1:0] cur_a;
  logic [ADDR_BITS-1:0] cur_b;
  logic [WORD_BITS-1:0] cur_count;
  logic [ADDR_BITS-1:0] step_a;
  logic [ADDR_BITS-1:0] step_b;
  snaw_ctl_t            ctl;

  logic [MAX_DIMS-1:0]  in_use;
  logic [MAX_DIMS-1:0]  size_zero;
  logic [MAX_DIMS-1:0]  inc;
  logic [MAX_DIMS:0]    carry;
  logic [ADDR_BITS-1:0] sfx_a [MAX_DIMS+1];
  logic [ADDR_BITS-1:0] sfx_b [MAX_DIMS+1];
  logic [ADDR_BITS-1:0] delta_a [MAX_DIMS];
  logic [ADDR_BITS-1:0] delta_b [MAX_DIMS];

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims  <= '0;
      dim_sizes <= '0;
      a_strides <= '0;
      b_strides <= '0;
      a_base    <= '0;
      b_base    <= '0;
    end else if (cfg_take) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_NUM_DIMS:  num_dims  <= cfg_data[NDIM_BITS-1:0];
        CFG_DIM_SIZES: dim_sizes <= cfg_data;
        CFG_A_STRIDES: a_strides <= cfg_data;
        CFG_B_STRIDES: b_strides <= cfg_data;
        CFG_A_BASE:    a_base    <= cfg_data[WORD_BITS-1:0];
        CFG_B_BASE:    b_base    <= cfg_data[WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // hold off requests until the cell steps reflect the new config
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= SETTLE_W'(SETTLE);
    end else if (cfg_take) begin
      settle <= SETTLE_W'(SETTLE);
    end else if (settle != '0) begin
      settle <= settle - SETTLE_W'(1);
    end
  end

  // counts above MAX_DIMS saturate
  assign nd_eff = (num_dims > MAX_DIMS) ? NDIM_EFF_BITS'(MAX_DIMS)
                                        : NDIM_EFF_BITS'(num_dims);

  // fields past bit 63 read as zero
  assign sizes_wide = {{PACK_BITS{1'b0}}, dim_sizes};
  assign astr_wide  = {{PACK_BITS{1'b0}}, a_strides};
  assign bstr_wide  = {{PACK_BITS{1'b0}}, b_strides};

  // ---------------------------------------------------------------- handshake
  assign in_ready = (settle == '0) & (~out_valid | out_ready);
  assign take     = in_valid & in_ready;
  assign zero_size = |size_zero;
  assign emit     = take & ~zero_size;
  assign start    = restart | ~walk_active;

  assign ctl.start   = start;
  assign ctl.advance = emit;

  assign cur_a     = start ? ADDR_BITS'(a_base) : a_pos;
  assign cur_b     = start ? ADDR_BITS'(b_base) : b_pos;
  assign cur_count = start ? '0 : count;

  // ---------------------------------------------------------------- cells
  // Cell MAX_DIMS-1 sits at the inner end; the carry enters there and
  // moves outward. At most one cell increments per tick.
  assign carry[MAX_DIMS] = 1'b1;
  assign sfx_a[MAX_DIMS] = '0;
  assign sfx_b[MAX_DIMS] = '0;
  assign last_w          = carry[0];

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_cell
    logic [DIM_BITS-1:0] size_k;
    assign size_k       = sizes_wide[k*DIM_BITS +: DIM_BITS];
    assign in_use[k]    = nd_eff > NDIM_EFF_BITS'(k);
    assign size_zero[k] = in_use[k] & (size_k == '0);

    snaw_cell #(
      .DIM_BITS  (DIM_BITS),
      .ADDR_BITS (ADDR_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .in_use    (in_use[k]),
      .size      (size_k),
      .a_stride  (astr_wide[k*DIM_BITS +: DIM_BITS]),
      .b_stride  (bstr_wide[k*DIM_BITS +: DIM_BITS]),
      .carry_in  (carry[k+1]),
      .carry_out (carry[k]),
      .inc       (inc[k]),
      .sfx_a_in  (sfx_a[k+1]),
      .sfx_b_in  (sfx_b[k+1]),
      .sfx_a_out (sfx_a[k]),
      .sfx_b_out (sfx_b[k]),
      .delta_a   (delta_a[k]),
      .delta_b   (delta_b[k])
    );
  end

  // one-hot select of the incrementing cell's step; none on the last element
  always_comb begin
    step_a = '0;
    step_b = '0;
    for (int k = 0; k < MAX_DIMS; k++) begin
      step_a = step_a | (inc[k] ? delta_a[k] : '0);
      step_b = step_b | (inc[k] ? delta_b[k] : '0);
    end
  end

  // ---------------------------------------------------------------- state
  always_ff @(posedge clk) begin
    if (rst) begin
      a_pos       <= '0;
      b_pos       <= '0;
      count       <= '0;
      walk_active <= 1'b0;
    end else if (emit) begin
      a_pos       <= cur_a + step_a;
      b_pos       <= cur_b + step_b;
      count       <= cur_count + WORD_BITS'(1);
      walk_active <= ~last_w;
    end else if (take) begin
      walk_active <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      a_addr    <= WORD_BITS'(cur_a);
      b_addr    <= WORD_BITS'(cur_b);
      out_index <= cur_count;
      last      <= last_w;
    end
  end

  // ---------------------------------------------------------------- checks
  a_first_index_zero: assert property (@(posedge clk) disable iff (rst)
    emit && start |=> out_index == '0)
    else $error("walk start did not give index zero");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    emit && last_w |=> !walk_active)
    else $error("walk still active after last element");

  a_zero_size_silent: assert property (@(posedge clk) disable iff (rst)
    take && zero_size && !out_valid |=> !out_valid)
    else $error("zero-sized shape produced a result");

  a_cfg_holds_off: assert property (@(posedge clk) disable iff (rst)
    cfg_take |=> !in_ready)
    else $error("request taken before config settled");

endmodule
